FILE: hw/rtl/iplc_pkg.sv
package iplc_pkg;

    localparam int WORD_W               = 16;
    localparam int MAX_PACKET_BYTES_DEF = 65535;

    // L4 kind codes
    localparam logic [1:0] KIND_NONE = 2'd0;
    localparam logic [1:0] KIND_UDP  = 2'd1;
    localparam logic [1:0] KIND_TCP  = 2'd2;

    localparam logic [7:0]  PROTO_TCP   = 8'd6;
    localparam logic [7:0]  PROTO_UDP   = 8'd17;
    localparam logic [3:0]  MIN_IHL     = 4'd5;
    localparam logic [15:0] UDP_MIN_LEN = 16'd8;

    // IPv4 header byte positions
    localparam logic [15:0] POS_IHL      = 16'd0;
    localparam logic [15:0] POS_PROTO    = 16'd9;
    localparam logic [15:0] POS_CHECK_HI = 16'd10;
    localparam logic [15:0] POS_CHECK_LO = 16'd11;
    localparam logic [15:0] POS_ADDR_LO  = 16'd12;
    localparam logic [15:0] POS_ADDR_HI  = 16'd19;

    // offsets inside the L4 segment
    localparam logic [15:0] UDP_OFS_LEN_LO   = 16'd5;
    localparam logic [15:0] UDP_OFS_CHECK_HI = 16'd6;
    localparam logic [15:0] UDP_OFS_CHECK_LO = 16'd7;
    localparam logic [15:0] TCP_OFS_CHECK_HI = 16'd16;
    localparam logic [15:0] TCP_OFS_CHECK_LO = 16'd17;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       is_last;
    } in_item_t;

    typedef struct packed {
        logic [15:0] ip_header_checksum;
        logic [15:0] l4_checksum;
        logic [1:0]  l4_kind;
    } out_item_t;

    // sums of a finished packet, handed to the finalise stage
    typedef struct packed {
        logic [15:0] header_sum;
        logic [15:0] transport_sum;
        logic [15:0] l4_length;
        logic [1:0]  l4_kind;
    } fin_item_t;

    // one's-complement add with end-around carry
    function automatic logic [15:0] oc_add(input logic [15:0] a, input logic [15:0] b);
        logic [16:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[15:0] + {15'd0, s[16]};
    endfunction

endpackage

FILE: hw/rtl/iplc_accum.sv
module iplc_accum
    import iplc_pkg::*;
#(
    parameter int MAX_PACKET_BYTES = MAX_PACKET_BYTES_DEF
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      in_valid,
    output logic      in_ready,
    input  in_item_t  in_item,
    output logic      fin_valid,
    input  logic      fin_ready,
    output fin_item_t fin_item
);

    localparam int POS_W = $clog2(MAX_PACKET_BYTES + 1);

    logic [POS_W-1:0] pos_reg, pos_next;
    logic [3:0]       ihl_reg, ihl_next;
    logic [7:0]       proto_reg, proto_next;
    logic [15:0]      hsum_reg, hsum_next;
    logic [15:0]      tsum_reg, tsum_next;
    logic [15:0]      udp_len_reg, udp_len_next;
    logic [7:0]       pend_reg, pend_next;
    logic             fin_valid_reg;
    fin_item_t        fin_reg, fin_next;

    logic [15:0] pos16, hdr_len, hdr_len_new, offset, part, udp_cover, total;
    logic [3:0]  ihl_eff, ihl_eff_new;
    logic        in_range, in_hdr, hdr_add, ts_add, take;

    always_comb begin
        pos16    = 16'(pos_reg);
        in_range = pos_reg < POS_W'(MAX_PACKET_BYTES);
        ihl_eff  = (ihl_reg < MIN_IHL) ? MIN_IHL : ihl_reg;
        hdr_len  = {10'd0, ihl_eff, 2'b00};
        in_hdr   = pos16 < hdr_len;
        offset   = pos16 - hdr_len;
        part     = pos16[0] ? {8'h00, in_item.data_byte} : {in_item.data_byte, 8'h00};

        udp_len_next = udp_len_reg;
        if (in_range && !in_hdr && proto_reg == PROTO_UDP && offset == UDP_OFS_LEN_LO) begin
            udp_len_next = {pend_reg, in_item.data_byte};
        end
        udp_cover = (udp_len_next < UDP_MIN_LEN) ? UDP_MIN_LEN : udp_len_next;

        hdr_add = in_range && in_hdr && pos16 != POS_CHECK_HI && pos16 != POS_CHECK_LO;
        ts_add  = 1'b0;
        if (in_range) begin
            if (in_hdr) begin
                ts_add = pos16 >= POS_ADDR_LO && pos16 <= POS_ADDR_HI;
            end else if (proto_reg == PROTO_UDP) begin
                ts_add = offset < udp_cover && offset != UDP_OFS_CHECK_HI
                         && offset != UDP_OFS_CHECK_LO;
            end else if (proto_reg == PROTO_TCP) begin
                ts_add = offset != TCP_OFS_CHECK_HI && offset != TCP_OFS_CHECK_LO;
            end
        end

        hsum_next  = hdr_add ? oc_add(hsum_reg, part) : hsum_reg;
        tsum_next  = ts_add ? oc_add(tsum_reg, part) : tsum_reg;
        ihl_next   = (in_range && pos16 == POS_IHL) ? in_item.data_byte[3:0] : ihl_reg;
        proto_next = (in_range && pos16 == POS_PROTO) ? in_item.data_byte : proto_reg;
        pend_next  = (in_range && !pos16[0]) ? in_item.data_byte : pend_reg;
        pos_next   = in_range ? pos_reg + POS_W'(1) : pos_reg;

        // packet summary as seen after this byte
        total       = 16'(pos_next);
        ihl_eff_new = (ihl_next < MIN_IHL) ? MIN_IHL : ihl_next;
        hdr_len_new = {10'd0, ihl_eff_new, 2'b00};

        fin_next.header_sum    = hsum_next;
        fin_next.transport_sum = tsum_next;
        fin_next.l4_kind       = KIND_NONE;
        fin_next.l4_length     = total - hdr_len_new;
        if (total >= hdr_len_new) begin
            if (proto_next == PROTO_UDP) begin
                fin_next.l4_kind   = KIND_UDP;
                fin_next.l4_length = udp_cover;
            end else if (proto_next == PROTO_TCP) begin
                fin_next.l4_kind = KIND_TCP;
            end
        end
    end

    assign in_ready  = !in_item.is_last || !fin_valid_reg || fin_ready;
    assign take      = in_valid && in_ready;
    assign fin_valid = fin_valid_reg;
    assign fin_item  = fin_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg       <= '0;
            ihl_reg       <= '0;
            proto_reg     <= '0;
            hsum_reg      <= '0;
            tsum_reg      <= '0;
            udp_len_reg   <= '0;
            pend_reg      <= '0;
            fin_valid_reg <= 1'b0;
        end else begin
            if (fin_valid_reg && fin_ready) begin
                fin_valid_reg <= 1'b0;
            end
            if (take) begin
                if (in_item.is_last) begin
                    fin_valid_reg <= 1'b1;
                    pos_reg       <= '0;
                    ihl_reg       <= '0;
                    proto_reg     <= '0;
                    hsum_reg      <= '0;
                    tsum_reg      <= '0;
                    udp_len_reg   <= '0;
                    pend_reg      <= '0;
                end else begin
                    pos_reg     <= pos_next;
                    ihl_reg     <= ihl_next;
                    proto_reg   <= proto_next;
                    hsum_reg    <= hsum_next;
                    tsum_reg    <= tsum_next;
                    udp_len_reg <= udp_len_next;
                    pend_reg    <= pend_next;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (take && in_item.is_last) begin
            fin_reg <= fin_next;
        end
    end

    a_clear_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        take && in_item.is_last |=> pos_reg == '0 && tsum_reg == '0 && hsum_reg == '0)
        else $error("packet state not cleared after last byte");

    a_pos_advance: assert property (@(posedge aclk) disable iff (!aresetn)
        take && !in_item.is_last && in_range |=> pos_reg == $past(pos_reg) + POS_W'(1))
        else $error("byte position did not advance");

    a_fin_held: assert property (@(posedge aclk) disable iff (!aresetn)
        fin_valid_reg && !fin_ready |=> fin_valid_reg)
        else $error("finished packet dropped while stalled");

endmodule

FILE: hw/rtl/iplc_final.sv
module iplc_final
    import iplc_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      fin_valid,
    output logic      fin_ready,
    input  fin_item_t fin_item,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_item
);

    logic      m_valid_reg;
    out_item_t m_item_reg, m_item_next;
    logic      load;
    logic [17:0] raw;
    logic [16:0] fold1;
    logic [15:0] fold2;
    logic [7:0]  proto;

    // pseudo-header protocol and length folded into the L4 sum in one go
    always_comb begin
        proto = (fin_item.l4_kind == KIND_UDP) ? PROTO_UDP : PROTO_TCP;
        raw   = 18'(fin_item.transport_sum) + 18'(proto) + 18'(fin_item.l4_length);
        fold1 = 17'(raw[15:0]) + 17'(raw[17:16]);
        fold2 = fold1[15:0] + 16'(fold1[16]);

        m_item_next.ip_header_checksum = ~fin_item.header_sum;
        m_item_next.l4_kind            = fin_item.l4_kind;
        m_item_next.l4_checksum        = (fin_item.l4_kind == KIND_NONE) ? 16'd0 : ~fold2;
    end

    assign fin_ready = !m_valid_reg || m_ready;
    assign load      = fin_valid && fin_ready;
    assign m_valid   = m_valid_reg;
    assign m_item    = m_item_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            m_item_reg <= m_item_next;
        end
    end

    a_none_is_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_item_reg.l4_kind == KIND_NONE |-> m_item_reg.l4_checksum == 16'd0)
        else $error("L4 checksum set with no L4 kind");

    a_load_shows: assert property (@(posedge aclk) disable iff (!aresetn)
        load |=> m_valid_reg && m_item_reg.l4_kind == $past(fin_item.l4_kind))
        else $error("finished packet not presented");

endmodule

FILE: hw/rtl/ipv4_l3_l4_checksum_engine.sv
// IPv4 header and UDP/TCP checksum engine. Feed a packet one byte per request
// on s_*, starting at the version/IHL byte, with is_last set on the final byte.
// One result request per packet appears on m_*: the complemented IP header
// checksum (check field read as zero), the complemented UDP or TCP checksum
// including the pseudo-header (zero when l4_kind is none) and the L4 kind.
// Throughput is one byte per cycle, back to back, set by the 16-bit
// end-around-carry add of each byte into the running sums. After the last
// byte is accepted it sits in the input register, is accumulated into the
// finished-packet register, and the pseudo-header fold lands in the output
// register, which presents the result on m_*. A last byte waits only
// while both result registers are full and m_ready is low. An IHL
// below 5 counts as 5; a UDP length below 8 counts as 8; bytes past the UDP
// length are not summed; bytes beyond MAX_PACKET_BYTES are ignored up to the
// last-byte mark. A UDP checksum of zero is passed out as zero.
module ipv4_l3_l4_checksum_engine
    import iplc_pkg::*;
#(
    parameter int MAX_PACKET_BYTES = MAX_PACKET_BYTES_DEF
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_item,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_item
);

    // input register
    logic      in_valid_reg;
    in_item_t  in_item_reg;
    logic      acc_ready;

    // accumulate -> finalise
    logic      fin_valid;
    logic      fin_ready;
    fin_item_t fin_item;

    // input stage refills while the accumulator takes its byte
    assign s_ready = !in_valid_reg || acc_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_item_reg <= s_item;
        end
    end

    // running header and transport sums, per-byte
    iplc_accum #(
        .MAX_PACKET_BYTES(MAX_PACKET_BYTES)
    ) u_accum (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (in_valid_reg),
        .in_ready (acc_ready),
        .in_item  (in_item_reg),
        .fin_valid(fin_valid),
        .fin_ready(fin_ready),
        .fin_item (fin_item)
    );

    // pseudo-header fold, complement and result register
    iplc_final u_final (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .fin_valid(fin_valid),
        .fin_ready(fin_ready),
        .fin_item (fin_item),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_item   (m_item)
    );

endmodule
